>>> sv/iba_pkg.sv
// Package for the integer to base-ASCII converter: widths, character codes,
// controller/datapath command and status structs and the digit-to-ASCII map.
// No dependencies.
`default_nettype none

package iba_pkg;

	// Width of the signed input value (supported range 8 to 64).
	localparam int VALUE_WIDTH = 32;

	// Dividend bits consumed per divider cycle.
	localparam int STEP_BITS   = 8;
	localparam int STEPS       = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_WIDTH   = STEPS * STEP_BITS;
	localparam int STEP_CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

	// Digit count holds 0 .. VALUE_WIDTH; digit store has VALUE_WIDTH entries.
	localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
	localparam int ADDR_WIDTH  = $clog2(VALUE_WIDTH);

	localparam int DIGIT_WIDTH = 6;
	localparam int RADIX_WIDTH = 6;
	localparam int CHAR_WIDTH  = 8;

	localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;

	localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO   = 8'h30;
	localparam logic [CHAR_WIDTH-1:0]  CHAR_A      = 8'h61;
	localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS  = 8'h2d;
	localparam logic [DIGIT_WIDTH-1:0] DIGIT_MAX   = 6'd9;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture value, sign and base
		logic div_step;    // advance the divider by one chunk
		logic rd;          // read the next digit, most significant first
		logic emit_sign;   // show '-' this cycle
		logic emit_digit;  // show the digit read last cycle
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_step;   // current divider cycle finishes a digit
		logic quot_zero;   // quotient after this digit is zero
		logic negative;    // value being converted is negative
		logic more;        // digits remain to be read
	} ctl_stat_t;

	function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
		logic [CHAR_WIDTH-1:0] d_ext;
		d_ext = {2'b00, d};
		if (d <= DIGIT_MAX)
			return CHAR_ZERO + d_ext;
		return CHAR_A + d_ext - 8'd10;
	endfunction

endpackage

`default_nettype wire

>>> sv/iba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module iba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> sv/iba_datapath.sv
// Datapath of the base-ASCII converter: radix register, chunked divider,
// digit store and character output. Depends on iba_pkg and iba_ram.
`default_nettype none

module iba_datapath
	import iba_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	input  wire logic                          cfg_wr_en,
	input  wire logic        [RADIX_WIDTH-1:0] cfg_wr_data,
	input  wire ctl_cmd_t                      cmd,
	output ctl_stat_t                          stat,
	output logic             [CHAR_WIDTH-1:0]  out_char,
	output logic                               is_last
);

	logic [RADIX_WIDTH-1:0] radix_q;
	logic [RADIX_WIDTH-1:0] base_q;
	logic [PAD_WIDTH-1:0]   work_q;
	logic [DIGIT_WIDTH-1:0] rem_q;
	logic [STEP_CNT_W-1:0]  step_q;
	logic [CNT_WIDTH-1:0]   cnt_q;
	logic                   neg_q;
	logic                   last_q;

	logic [VALUE_WIDTH-1:0] mag;
	logic [RADIX_WIDTH-1:0] base_eff;
	logic [STEP_BITS-1:0]   qbits;
	logic [DIGIT_WIDTH-1:0] rem_next;
	logic [PAD_WIDTH-1:0]   work_next;
	logic [CNT_WIDTH-1:0]   cnt_dec;
	logic [DIGIT_WIDTH-1:0] rd_digit;
	logic                   last_step;

	assign mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

	always_comb begin
		if (radix_q < RADIX_MIN)
			base_eff = RADIX_MIN;
		else if (radix_q > RADIX_MAX)
			base_eff = RADIX_MAX;
		else
			base_eff = radix_q;
	end

	// Restoring division over one chunk of the dividend, MSB first.
	always_comb begin
		logic [DIGIT_WIDTH:0]   t;
		logic [DIGIT_WIDTH-1:0] r;
		r     = rem_q;
		qbits = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r, work_q[PAD_WIDTH-1-i]};
			if (t >= {1'b0, base_q}) begin
				t = t - {1'b0, base_q};
				qbits[STEP_BITS-1-i] = 1'b1;
			end
			r = t[DIGIT_WIDTH-1:0];
		end
		rem_next = r;
	end

	assign work_next = PAD_WIDTH'({work_q, qbits});
	assign last_step = (step_q == STEP_CNT_W'(STEPS - 1));
	assign cnt_dec   = cnt_q - CNT_WIDTH'(1);

	assign stat.last_step = last_step;
	assign stat.quot_zero = (work_next == '0);
	assign stat.negative  = neg_q;
	assign stat.more      = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
			step_q  <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			if (cfg_wr_en)
				radix_q <= cfg_wr_data;
			if (cmd.load) begin
				step_q <= '0;
				cnt_q  <= '0;
				neg_q  <= value[VALUE_WIDTH-1];
			end else if (cmd.div_step) begin
				if (last_step) begin
					step_q <= '0;
					cnt_q  <= cnt_q + CNT_WIDTH'(1);
				end else begin
					step_q <= step_q + STEP_CNT_W'(1);
				end
			end else if (cmd.rd) begin
				cnt_q  <= cnt_dec;
				last_q <= (cnt_q == CNT_WIDTH'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= base_eff;
			work_q <= PAD_WIDTH'(mag);
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			work_q <= work_next;
			rem_q  <= last_step ? '0 : rem_next;
		end
	end

	iba_ram #(
		.WIDTH (DIGIT_WIDTH),
		.DEPTH (VALUE_WIDTH)
	) u_digit_store (
		.clk   (clk),
		.we    (cmd.div_step & last_step),
		.waddr (cnt_q[ADDR_WIDTH-1:0]),
		.wdata (rem_next),
		.re    (cmd.rd),
		.raddr (cnt_dec[ADDR_WIDTH-1:0]),
		.rdata (rd_digit)
	);

	assign out_char = cmd.emit_sign ? CHAR_MINUS : digit_char(rd_digit);
	assign is_last  = cmd.emit_digit & last_q;

endmodule

`default_nettype wire

>>> sv/iba_ctrl.sv
// Controller of the base-ASCII converter: sequences load, division,
// sign and digit output. Depends on iba_pkg.
`default_nettype none

module iba_ctrl
	import iba_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire ctl_stat_t stat,
	output ctl_cmd_t       cmd,
	output logic           busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_RD,
		ST_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (stat.last_step && stat.quot_zero)
						state_q <= stat.negative ? ST_SIGN : ST_RD;
				end
				ST_SIGN: state_q <= ST_OUT;
				ST_RD:   state_q <= ST_OUT;
				ST_OUT: begin
					if (!stat.more)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.load = start;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_SIGN: begin
				cmd.emit_sign = 1'b1;
				cmd.rd        = 1'b1;
			end
			ST_RD:   cmd.rd = 1'b1;
			ST_OUT: begin
				cmd.emit_digit = 1'b1;
				cmd.rd         = stat.more;
			end
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

>>> sv/integer_to_base_ascii.sv
// Integer to base-ASCII converter: a value taken at the accepting edge is divided chunk by chunk
// (STEPS = 4 chunk steps per digit at 32 bits); for a negative value the '-' beat then follows,
// then the first digit in the cycle after it, then one digit per cycle.
// The next value is taken only after the last character, once busy has fallen.
// The receiver cannot stall; each character shows for one cycle on strobe.
// Reset (arst_n low) returns to idle and sets radix to ten.
`default_nettype none

module integer_to_base_ascii
	import iba_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input beat: accepted when start is high and busy is low.
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	// Radix register write.
	input  wire logic                          cfg_wr_en,
	input  wire logic        [RADIX_WIDTH-1:0] cfg_wr_data,
	// Output beat: one character per strobe cycle.
	output logic                               strobe,
	output logic             [CHAR_WIDTH-1:0]  out_char,
	output logic                               is_last
);

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	// Sequence the conversion: load, divide digit by digit, then emit.
	iba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Hold the radix, divide the magnitude, store digits, map to ASCII.
	iba_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.stat        (stat),
		.out_char    (out_char),
		.is_last     (is_last)
	);

	// A beat leaves on the sign cycle and on each digit cycle.
	assign strobe = cmd.emit_sign | cmd.emit_digit;

endmodule

`default_nettype wire

>>> sv/iba_checker.sv
// Port-level checker for the base-ASCII converter, bound to the top level.
// Depends on iba_pkg.
`default_nettype none

module iba_checker
	import iba_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    start,
	input wire logic                    busy,
	input wire logic                    strobe,
	input wire logic [CHAR_WIDTH-1:0]   out_char,
	input wire logic                    is_last
);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("output beat while idle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted input did not raise busy");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && out_char == CHAR_MINUS) |-> !is_last)
		else $error("sign flagged as last character");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && is_last) |=> (!busy && !strobe))
		else $error("not idle after last character");

	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		is_last |-> strobe)
		else $error("last flag without strobe");

endmodule

bind integer_to_base_ascii iba_checker u_iba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.strobe   (strobe),
	.out_char (out_char),
	.is_last  (is_last)
);

`default_nettype wire
